[rtl/fcpu_pkg.sv]
package fcpu_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned TotW  = 7;
  localparam int unsigned ExpW  = 4;
  localparam int unsigned CfgW  = 7;

  localparam logic [TotW-1:0] TotReset = 7'd64;
  localparam logic [ExpW-1:0] ExpReset = 4'd11;

  // register indexes
  localparam logic CfgTotal = 1'b0;
  localparam logic CfgExp   = 1'b1;

  // operation codes
  localparam logic OpPack   = 1'b0;
  localparam logic OpUnpack = 1'b1;

  // clamped geometry of the custom format
  typedef struct packed {
    logic [6:0] t;   // 4..64
    logic [3:0] e;   // 2..11
    logic [5:0] sb;  // 1..61
  } geom_t;

  // leading one position of a 52-bit fraction
  function automatic logic [5:0] msb52(input logic [51:0] m);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

[rtl/float_custom_format_pack_unpack_top.sv]
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | operation, value
// output  | out_valid | out_ready | result_value, range_error
// config  | cfg_we    | -         | cfg_index, cfg_data
// One word per cycle while the output is not stalled; each word passes the input register, then the result register.
// The conversion is one combinational pass between the two registers.
// Reset clears both valid flags; config returns to 64-bit word, 11-bit exponent.
// A stalled output holds its word; input stays open while the result moves on.
module float_custom_format_pack_unpack_top
  import fcpu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [WordW-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] result_value,
  output logic             range_error,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CfgW-1:0]  cfg_data
);

  geom_t geom;
  logic             s1_valid;
  logic             s1_op;
  logic [WordW-1:0] s1_value;
  logic [WordW-1:0] res;
  logic             err;
  logic             s1_ready;

  fcpu_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .geom
  );

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op    <= operation;
      s1_value <= value;
    end
  end

  fcpu_core u_core (
    .geom, .operation(s1_op), .value(s1_value), .res, .err
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      result_value <= res;
      range_error  <= err;
    end
  end

endmodule

[rtl/fcpu_core.sv]
module fcpu_core
  import fcpu_pkg::*;
(
  input  geom_t             geom,
  input  logic              operation,
  input  logic [WordW-1:0]  value,
  output logic [WordW-1:0]  res,
  output logic              err
);

  // pack side
  logic        p_sgn;
  logic [10:0] p_ef;
  logic [51:0] p_m;
  logic [5:0]  p_msb;
  logic [51:0] frac52;
  logic signed [12:0] shift;
  logic [63:0] sig;
  logic [5:0]  k;
  logic [53:0] s_sum;
  logic [51:0] lo_mask;
  logic [51:0] lo;
  logic [63:0] sb_one;
  logic signed [13:0] biased;
  logic [11:0] emax;
  logic [10:0] bias;
  logic [63:0] pack_res;
  logic        pack_err;

  // unpack side
  logic [63:0] w;
  logic [63:0] fr;
  logic [10:0] ex;
  logic        u_s;
  logic signed [12:0] unb;
  logic [51:0] u_f52;
  logic signed [13:0] d;
  logic [52:0] mant;
  logic [63:0] unpack_res;
  logic        unpack_err;

  assign bias = 11'((12'd1 << (geom.e - 4'd1)) - 12'd1);
  assign emax = 12'((13'd1 << geom.e) - 13'd1);
  assign sb_one = 64'd1 << geom.sb;

  // normalize and round fraction, then assemble the packed word and range error
  always_comb begin
    p_sgn  = value[63];
    p_ef   = value[62:52];
    p_m    = value[51:0];
    p_msb  = msb52(p_m);
    if (p_ef == 11'd0) begin
      shift  = 13'(signed'({7'd0, p_msb})) - 13'sd1074;
      frac52 = 52'(p_m << (6'd52 - p_msb));
    end else begin
      shift  = 13'(signed'({2'd0, p_ef})) - 13'sd1023;
      frac52 = p_m;
    end
    k       = 6'd52 - geom.sb;
    lo_mask = 52'((53'd1 << k) - 53'd1);
    lo      = frac52 & lo_mask;
    // (lo << (sb+1)) + frac52; lo<<(sb+1) < 2^53, so bit 53 is the carry
    s_sum   = 54'({2'b0, lo} << (geom.sb + 6'd1)) + {2'b0, frac52};
    if (geom.sb >= 6'd52) begin
      sig = {12'd0, frac52} << (geom.sb - 6'd52);
    end else begin
      sig = 64'(frac52 >> k) + 64'(s_sum[53]);
    end
    if (sig >= sb_one) begin
      sig   = 64'd0;
      shift = shift + 13'sd1;
    end
    biased   = 14'(shift) + 14'(signed'({3'd0, bias}));
    pack_res = ({63'd0, p_sgn} << (geom.t - 7'd1)) |
               (64'(biased[10:0]) << geom.sb) | sig;
    pack_err = 1'b0;
    if (p_ef == 11'd0 && p_m == 52'd0) begin
      pack_res = 64'd0;
    end else if (p_ef == 11'h7FF ||
                 biased < 14'sd0 || biased > 14'(signed'({2'd0, emax}))) begin
      pack_res = 64'd0;
      pack_err = 1'b1;
    end
  end

  // field extract and rebias
  always_comb begin
    w  = (geom.t == 7'd64) ? value : (value & 64'((65'd1 << geom.t) - 65'd1));
    fr = w & 64'((65'd1 << geom.sb) - 65'd1);
    ex = 11'((w >> geom.sb) & 64'(emax));
    u_s = w[6'(geom.t - 7'd1)];
    unb = 13'(signed'({2'd0, ex})) - 13'(signed'({2'd0, bias}));
    if (geom.sb >= 6'd52) u_f52 = 52'(fr >> (geom.sb - 6'd52));
    else                  u_f52 = 52'(fr << (6'd52 - geom.sb));
    d    = -14'sd1022 - 14'(unb);
    mant = (d <= 14'sd52) ? ({1'b1, u_f52} >> d[5:0]) : 53'd0;
    unpack_err = 1'b0;
    if (w == 64'd0) begin
      unpack_res = 64'd0;
    end else if (unb > 13'sd1023) begin
      unpack_res = 64'd0;
      unpack_err = 1'b1;
    end else if (unb >= -13'sd1022) begin
      unpack_res = {u_s, 11'(unb + 13'sd1023), u_f52};
    end else begin
      unpack_res = {u_s, 11'd0, mant[51:0]};
    end
  end

  assign res = (operation == OpUnpack) ? unpack_res : pack_res;
  assign err = (operation == OpUnpack) ? unpack_err : pack_err;

endmodule

[rtl/fcpu_cfg.sv]
module fcpu_cfg
  import fcpu_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output geom_t           geom
);

  logic [TotW-1:0] total_bits;
  logic [ExpW-1:0] exponent_bits;
  logic [6:0] tt;
  logic [3:0] ee;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits    <= TotReset;
      exponent_bits <= ExpReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgTotal) total_bits <= cfg_data[TotW-1:0];
      else                       exponent_bits <= cfg_data[ExpW-1:0];
    end
  end

  // clamp geometry
  always_comb begin
    tt = total_bits;
    if (tt < 7'd4)  tt = 7'd4;
    if (tt > 7'd64) tt = 7'd64;
    ee = exponent_bits;
    if (ee < 4'd2)  ee = 4'd2;
    if (ee > 4'd11) ee = 4'd11;
    if (7'(ee) > tt - 7'd2) ee = 4'(tt - 7'd2);
    geom.t  = tt;
    geom.e  = ee;
    geom.sb = 6'(tt - 7'(ee) - 7'd1);
  end

endmodule

[rtl/fcpu_checker.sv]
module fcpu_checker
  import fcpu_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WordW-1:0] result_value,
  input logic             range_error
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("output word changed while stalled");

  // an error result carries a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> result_value == 64'd0)
    else $error("error with nonzero word");

  // input open whenever output is drained
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // no output right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind float_custom_format_pack_unpack_top fcpu_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .result_value, .range_error
);
